>>> design/spce_pkg.sv
// spce_pkg: types, constants and helper functions of the scrambled packet CRC encoder.
// No dependencies; every other file of the block uses it by scoped name.
package spce_pkg;

  localparam int ADDR_W               = 40;
  localparam int CFG_IDX_W            = 2;
  localparam int WHITEN_LEN           = 35;
  localparam int XOROUT_LEN           = 28;
  localparam int SUM_W                = 7;
  localparam int MAX_PACKET_BYTES_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSMIT_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE       = 2'd2;

  localparam logic [1:0] KIND_PREAMBLE = 2'd0;
  localparam logic [1:0] KIND_ADDRESS  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
  localparam logic [1:0] KIND_CRC      = 2'd3;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_SEED     = 16'hB5D2;
  localparam logic [15:0] CRC_MSB      = 16'h8000;
  localparam logic [7:0]  PREAMBLE     = 8'h55;
  localparam logic [2:0]  ALEN_RESET   = 3'd5;

  typedef struct packed {
    logic [2:0]        alen;
    logic [ADDR_W-1:0] addr;
    logic              crc_en;
  } cfg_t;

  typedef struct packed {
    logic              hdr;
    logic              pre;
    logic [2:0]        alen;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pbyte;
    logic              err;
    logic              last;
    logic              crc_en;
    logic [15:0]       xorv;
  } cmd_t;

  function automatic logic [7:0] whiten(input logic [5:0] idx);
    logic [7:0] r;
    case (idx)
      6'd0:  r = 8'he3;  6'd1:  r = 8'hb1;  6'd2:  r = 8'h4b;  6'd3:  r = 8'hea;
      6'd4:  r = 8'h85;  6'd5:  r = 8'hbc;  6'd6:  r = 8'he5;  6'd7:  r = 8'h66;
      6'd8:  r = 8'h0d;  6'd9:  r = 8'hae;  6'd10: r = 8'h8c;  6'd11: r = 8'h88;
      6'd12: r = 8'h12;  6'd13: r = 8'h69;  6'd14: r = 8'hee;  6'd15: r = 8'h1f;
      6'd16: r = 8'hc7;  6'd17: r = 8'h62;  6'd18: r = 8'h97;  6'd19: r = 8'hd5;
      6'd20: r = 8'h0b;  6'd21: r = 8'h79;  6'd22: r = 8'hca;  6'd23: r = 8'hcc;
      6'd24: r = 8'h1b;  6'd25: r = 8'h5d;  6'd26: r = 8'h19;  6'd27: r = 8'h10;
      6'd28: r = 8'h24;  6'd29: r = 8'hd3;  6'd30: r = 8'hdc;  6'd31: r = 8'h3f;
      6'd32: r = 8'h8e;  6'd33: r = 8'hc5;  6'd34: r = 8'h2f;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] xorout(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:  r = 16'h0000; 5'd1:  r = 16'h3448; 5'd2:  r = 16'h9BA7; 5'd3:  r = 16'h8BBB;
      5'd4:  r = 16'h85E1; 5'd5:  r = 16'h3E8C; 5'd6:  r = 16'h451E; 5'd7:  r = 16'h18E6;
      5'd8:  r = 16'h6B24; 5'd9:  r = 16'hE7AB; 5'd10: r = 16'h3828; 5'd11: r = 16'h8148;
      5'd12: r = 16'hD461; 5'd13: r = 16'hF494; 5'd14: r = 16'h2503; 5'd15: r = 16'h691D;
      5'd16: r = 16'hFE8B; 5'd17: r = 16'h9BA7; 5'd18: r = 16'h8B17; 5'd19: r = 16'h2920;
      5'd20: r = 16'h8B5F; 5'd21: r = 16'h61B1; 5'd22: r = 16'hD391; 5'd23: r = 16'h7401;
      5'd24: r = 16'h2138; 5'd25: r = 16'h129F; 5'd26: r = 16'hB3A0; 5'd27: r = 16'h2988;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/spce_if.sv
// spce_if: valid/ready channel interfaces of the encoder (payload in, packet out, config).
// Depends on spce_pkg for the field widths.
interface spce_payload_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_of_payload;
  modport source (output valid, payload_byte, end_of_payload, input ready);
  modport sink   (input valid, payload_byte, end_of_payload, output ready);
endinterface

interface spce_packet_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic [1:0] byte_kind;
  logic       end_of_packet;
  logic       length_error;
  modport source (output valid, packet_byte, byte_kind, end_of_packet, length_error,
                  input ready);
  modport sink   (input valid, packet_byte, byte_kind, end_of_packet, length_error,
                  output ready);
endinterface

interface spce_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spce_pkg::CFG_IDX_W-1:0] index;
  logic [spce_pkg::ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/spce_queue.sv
// spce_queue: two-entry command queue between the front and the back of the encoder.
// Depends on spce_pkg (cmd_t).
module spce_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  spce_pkg::cmd_t   push_cmd,
  output logic             pop_valid,
  input  logic             pop,
  output spce_pkg::cmd_t   pop_cmd
);

  localparam int DEPTH = 2;

  spce_pkg::cmd_t mem [DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/spce_front.sv
// spce_front: accepts payload items, checks table limits, whitens the byte and
// builds one command per item for the back. Depends on spce_pkg.
module spce_front #(
  parameter int MAX_PACKET_BYTES = spce_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  spce_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output spce_pkg::cmd_t cmd
);

  localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int SW    = spce_pkg::SUM_W;

  logic             in_packet;
  logic [IDX_W-1:0] pidx;

  logic [2:0]    alen;
  logic [SW-1:0] alen_s, hdr_s, cnt_s, crcb_s, pnext, xi, widx;
  logic          ok, accept;
  logic [15:0]   xorv;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  always_comb begin
    if (cfg.alen < 3'd3) begin
      alen = 3'd3;
    end else if (cfg.alen > 3'd5) begin
      alen = 3'd5;
    end else begin
      alen = cfg.alen;
    end
    alen_s = SW'(alen);
    hdr_s  = alen_s + ((alen < 3'd4) ? SW'(1) : SW'(0));
    cnt_s  = SW'(pidx);
    crcb_s = cfg.crc_en ? SW'(2) : SW'(0);
    ok = ((alen_s + cnt_s) < SW'(spce_pkg::WHITEN_LEN)) &&
         ((hdr_s + cnt_s + SW'(1) + crcb_s) <= SW'(MAX_PACKET_BYTES)) &&
         (!cfg.crc_en || ((alen_s - SW'(3) + cnt_s + SW'(1)) < SW'(spce_pkg::XOROUT_LEN)));
    pnext = ok ? (cnt_s + SW'(1)) : cnt_s;
    xi    = alen_s - SW'(3) + pnext;
    widx  = alen_s + cnt_s;
    if ((pnext != SW'(0)) && (xi < SW'(spce_pkg::XOROUT_LEN))) begin
      xorv = spce_pkg::xorout(xi[4:0]);
    end else begin
      xorv = 16'h0000;
    end
  end

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  always_comb begin
    cmd.hdr    = !in_packet;
    cmd.pre    = (alen < 3'd4);
    cmd.alen   = alen;
    cmd.addr   = cfg.addr;
    cmd.pbyte  = rev8(in_byte) ^ spce_pkg::whiten(widx[5:0]);
    cmd.err    = !ok;
    cmd.last   = in_last;
    cmd.crc_en = cfg.crc_en;
    cmd.xorv   = xorv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet <= 1'b0;
      pidx      <= '0;
    end else if (accept) begin
      if (in_last) begin
        in_packet <= 1'b0;
        pidx      <= '0;
      end else begin
        in_packet <= 1'b1;
        pidx      <= pnext[IDX_W-1:0];
      end
    end
  end

endmodule

>>> design/spce_back.sv
// spce_back: byte sequencer that expands each command into header, payload and CRC
// bytes, runs the CRC and drives the output register. Depends on spce_pkg.
module spce_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  spce_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic [1:0]     out_kind,
  output logic           out_eop,
  output logic           out_err
);

  typedef enum logic [2:0] {PH_PRE, PH_ADDR, PH_PAY, PH_CRC_HI, PH_CRC_LO} phase_t;

  phase_t      phase;
  logic        mid;
  logic [2:0]  aidx;
  logic [15:0] crc;

  phase_t      ph, ph_next;
  logic [2:0]  ai, ai_next, sel;
  logic [7:0]  b;
  logic [1:0]  kind;
  logic        err, upd, done, emit;

  always_comb begin
    if (mid) begin
      ph = phase;
      ai = aidx;
    end else begin
      ph = cmd.hdr ? (cmd.pre ? PH_PRE : PH_ADDR) : PH_PAY;
      ai = 3'd0;
    end
    sel     = cmd.alen - 3'd1 - ai;
    b       = 8'h00;
    kind    = spce_pkg::KIND_PAYLOAD;
    err     = 1'b0;
    upd     = 1'b0;
    done    = 1'b0;
    ph_next = ph;
    ai_next = ai;
    unique case (ph)
      PH_PRE: begin
        b       = spce_pkg::PREAMBLE;
        kind    = spce_pkg::KIND_PREAMBLE;
        ph_next = PH_ADDR;
      end
      PH_ADDR: begin
        b       = cmd.addr[{sel, 3'b000} +: 8] ^ spce_pkg::whiten({3'b000, ai});
        kind    = spce_pkg::KIND_ADDRESS;
        upd     = 1'b1;
        ai_next = ai + 3'd1;
        ph_next = (ai == cmd.alen - 3'd1) ? PH_PAY : PH_ADDR;
      end
      PH_PAY: begin
        b       = cmd.err ? 8'h00 : cmd.pbyte;
        err     = cmd.err;
        upd     = !cmd.err;
        ph_next = PH_CRC_HI;
        done    = !(cmd.last && cmd.crc_en);
      end
      PH_CRC_HI: begin
        b       = crc[15:8] ^ cmd.xorv[15:8];
        kind    = spce_pkg::KIND_CRC;
        ph_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        b    = crc[7:0] ^ cmd.xorv[7:0];
        kind = spce_pkg::KIND_CRC;
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign emit    = cmd_valid && (!out_valid || out_ready);
  assign cmd_pop = emit && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      phase     <= PH_PRE;
      aidx      <= 3'd0;
      crc       <= spce_pkg::CRC_SEED;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_byte  <= b;
        out_kind  <= kind;
        out_err   <= err;
        out_eop   <= done && cmd.last;
        mid       <= !done;
        phase     <= ph_next;
        aidx      <= ai_next;
        if (done && cmd.last) begin
          crc <= spce_pkg::CRC_SEED;
        end else if (upd) begin
          crc <= spce_pkg::crc_byte(crc, b);
        end
      end
    end
  end

endmodule

>>> design/scrambled_packet_crc_encoder.sv
// scrambled_packet_crc_encoder: top level; configuration registers, front, queue, back.
// Depends on spce_pkg, spce_if, spce_front, spce_queue and spce_back.
//
// Turns a stream of payload bytes into whitened packet bytes. A payload item that is
// neither first nor last gives one output byte and the block takes one such item per
// cycle while the queue is not full. The first item of a packet also gives the header
// (optional 0x55 preamble and three to five address bytes), and with CRC enabled the
// last item adds two CRC bytes; the back sequencer emits one byte per cycle into the
// output register while the receiver is ready, and a two-entry queue lets the front
// keep accepting until it fills. Dropped bytes come out as a flagged zero byte that is
// not part of the packet. Configuration is always ready.
module scrambled_packet_crc_encoder #(
  parameter int MAX_PACKET_BYTES = spce_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  spce_payload_if.sink   payload,
  spce_packet_if.source  packet,
  spce_cfg_if.sink       cfg
);

  spce_pkg::cfg_t cfg_reg;

  logic           f_valid, f_ready, q_valid, q_pop;
  spce_pkg::cmd_t f_cmd, q_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.alen   <= spce_pkg::ALEN_RESET;
      cfg_reg.addr   <= '0;
      cfg_reg.crc_en <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        spce_pkg::CFG_ADDRESS_LENGTH:   cfg_reg.alen   <= cfg.data[2:0];
        spce_pkg::CFG_TRANSMIT_ADDRESS: cfg_reg.addr   <= cfg.data;
        spce_pkg::CFG_CRC_ENABLE:       cfg_reg.crc_en <= cfg.data[0];
        default: ;
      endcase
    end
  end

  spce_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_reg),
    .in_valid  (payload.valid),
    .in_ready  (payload.ready),
    .in_byte   (payload.payload_byte),
    .in_last   (payload.end_of_payload),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  spce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  spce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (packet.valid),
    .out_ready (packet.ready),
    .out_byte  (packet.packet_byte),
    .out_kind  (packet.byte_kind),
    .out_eop   (packet.end_of_packet),
    .out_err   (packet.length_error)
  );

endmodule

>>> design/spce_checker.sv
// spce_checker: port-level assertions on the encoder output, bound to the top level.
// Depends on spce_pkg and scrambled_packet_crc_encoder.
module spce_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_eop,
  input logic       out_err
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_drop_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |->
      (out_kind == spce_pkg::KIND_PAYLOAD) && (out_byte == 8'h00))
    else $error("dropped item not a zero payload byte");

  a_eop_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_eop) |->
      (out_kind == spce_pkg::KIND_PAYLOAD) || (out_kind == spce_pkg::KIND_CRC))
    else $error("packet ends on a header byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("stalled output item changed");

endmodule

bind scrambled_packet_crc_encoder spce_checker u_spce_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (packet.valid),
  .out_ready (packet.ready),
  .out_byte  (packet.packet_byte),
  .out_kind  (packet.byte_kind),
  .out_eop   (packet.end_of_packet),
  .out_err   (packet.length_error)
);

>>> dv/scrambled_packet_crc_encoder_test.sv
`timescale 1ns / 1ps
// Testbench of the scrambled packet CRC encoder: directed and random packets with
// randomly idling sender and receiver, checked against an in-bench packet encoder.
// Depends on spce_pkg, spce_if and the scrambled_packet_crc_encoder top level.
module scrambled_packet_crc_encoder_test;

  localparam int MAX_BYTES   = 32;
  localparam int WHITEN_N    = 35;
  localparam int XOROUT_N    = 28;
  localparam int RANDOM_ITEMS = 260;
  localparam int REPORT_MAX  = 10;

  localparam logic [15:0] POLY      = 16'h1021;
  localparam logic [15:0] SEED      = 16'hB5D2;
  localparam logic [7:0]  PREAMBLE  = 8'h55;

  localparam logic [7:0] WHITEN_TAB [WHITEN_N] = '{
    8'he3, 8'hb1, 8'h4b, 8'hea, 8'h85, 8'hbc, 8'he5, 8'h66,
    8'h0d, 8'hae, 8'h8c, 8'h88, 8'h12, 8'h69, 8'hee, 8'h1f,
    8'hc7, 8'h62, 8'h97, 8'hd5, 8'h0b, 8'h79, 8'hca, 8'hcc,
    8'h1b, 8'h5d, 8'h19, 8'h10, 8'h24, 8'hd3, 8'hdc, 8'h3f,
    8'h8e, 8'hc5, 8'h2f};

  localparam logic [15:0] XOROUT_TAB [XOROUT_N] = '{
    16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C,
    16'h451E, 16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h8148,
    16'hD461, 16'hF494, 16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7,
    16'h8B17, 16'h2920, 16'h8B5F, 16'h61B1, 16'hD391, 16'h7401,
    16'h2138, 16'h129F, 16'hB3A0, 16'h2988};

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic [1:0] kind;
    logic       eop;
    logic       err;
  } pkt_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spce_payload_if pl_if ();
  spce_packet_if  pk_if ();
  spce_cfg_if     cfg_if ();

  scrambled_packet_crc_encoder #(.MAX_PACKET_BYTES(MAX_BYTES)) dut (
    .clk     (clk),
    .rst     (rst),
    .payload (pl_if),
    .packet  (pk_if),
    .cfg     (cfg_if)
  );

  always #2 clk = ~clk;

  // encoder copy: registers and packet state
  logic [2:0]  reg_alen;
  logic [39:0] reg_addr;
  logic        reg_crc_en;
  logic [15:0] crc_acc;
  int          pay_idx;
  bit          in_pkt;

  pkt_item_t pending_bytes[$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        pl_up = 1'b0;
  bit        cfg_up = 1'b0;
  bit        rdy_up = 1'b0;
  int        idle_left[2] = '{0, 0};
  bit        idle_calm[2] = '{1'b0, 1'b0};

  // side 0: payload sender, side 1: packet receiver
  function automatic int draw_gap(input int side);
    if (idle_left[side] == 0) begin
      idle_calm[side] = ($urandom_range(0, 3) == 0);
      idle_left[side] = $urandom_range(8, 40);
    end
    idle_left[side]--;
    return idle_calm[side] ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ({c[14:0], 1'b0} ^ POLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  task automatic queue_result(input logic [7:0] b, input logic [1:0] kind,
                              input logic eop, input logic err);
    pkt_item_t it;
    it.pkt_byte = b;
    it.kind     = kind;
    it.eop      = eop;
    it.err      = err;
    pending_bytes.push_back(it);
  endtask

  task automatic encode_payload_byte(input logic [7:0] pb, input logic last);
    int         alen;
    int         hdr;
    int         crcb;
    int         xi;
    bit         ok;
    logic [7:0] b;
    logic [15:0] c;
    alen = (reg_alen < 3) ? 3 : ((reg_alen > 5) ? 5 : int'(reg_alen));
    hdr  = alen + ((alen < 4) ? 1 : 0);
    crcb = reg_crc_en ? 2 : 0;
    if (!in_pkt) begin
      crc_acc = SEED;
      pay_idx = 0;
      if (alen < 4) queue_result(PREAMBLE, spce_pkg::KIND_PREAMBLE, 1'b0, 1'b0);
      for (int i = 0; i < alen; i++) begin
        b = reg_addr[8*(alen-1-i) +: 8] ^ WHITEN_TAB[i];
        crc_acc = crc16_step(crc_acc, b);
        queue_result(b, spce_pkg::KIND_ADDRESS, 1'b0, 1'b0);
      end
      in_pkt = 1'b1;
    end
    ok = (alen + pay_idx < WHITEN_N) && (hdr + pay_idx + 1 + crcb <= MAX_BYTES) &&
         (!reg_crc_en || (alen - 3 + pay_idx + 1 < XOROUT_N));
    if (ok) begin
      b = mirror_byte(pb) ^ WHITEN_TAB[alen + pay_idx];
      crc_acc = crc16_step(crc_acc, b);
      queue_result(b, spce_pkg::KIND_PAYLOAD, last && !reg_crc_en, 1'b0);
      pay_idx++;
    end else begin
      queue_result(8'h00, spce_pkg::KIND_PAYLOAD, last && !reg_crc_en, 1'b1);
    end
    if (last) begin
      if (reg_crc_en) begin
        xi = alen - 3 + pay_idx;
        c  = crc_acc;
        if (pay_idx != 0 && xi < XOROUT_N) c = c ^ XOROUT_TAB[xi];
        queue_result(c[15:8], spce_pkg::KIND_CRC, 1'b0, 1'b0);
        queue_result(c[7:0], spce_pkg::KIND_CRC, 1'b1, 1'b0);
      end
      in_pkt  = 1'b0;
      pay_idx = 0;
      crc_acc = SEED;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_gap(0);
    if (cfg_up) begin
      cfg_if.valid <= 1'b0;
      cfg_up = 1'b0;
    end
    if (gap > 0) begin
      if (pl_up) begin
        pl_if.valid <= 1'b0;
        pl_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    pl_if.valid          <= 1'b1;
    pl_if.payload_byte   <= b;
    pl_if.end_of_payload <= last;
    pl_up = 1'b1;
    do @(posedge clk); while (!pl_if.ready);
    encode_payload_byte(b, last);
    items_sent++;
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  task automatic wait_drained();
    if (pl_up) begin
      pl_if.valid <= 1'b0;
      pl_up = 1'b0;
    end
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] wr_index, input logic [39:0] wr_data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= wr_index;
    cfg_if.data  <= wr_data;
    cfg_up = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (wr_index)
      spce_pkg::CFG_ADDRESS_LENGTH:   reg_alen   = wr_data[2:0];
      spce_pkg::CFG_TRANSMIT_ADDRESS: reg_addr   = wr_data;
      spce_pkg::CFG_CRC_ENABLE:       reg_crc_en = wr_data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] alen, input logic [39:0] addr, input logic crc_en);
    wait_drained();
    cfg_write(spce_pkg::CFG_ADDRESS_LENGTH, {37'd0, alen});
    cfg_write(spce_pkg::CFG_TRANSMIT_ADDRESS, addr);
    cfg_write(spce_pkg::CFG_CRC_ENABLE, {39'd0, crc_en});
  endtask

  function automatic logic [39:0] rand_addr();
    logic [39:0] a;
    case ($urandom_range(0, 7))
      0: a = '0;
      1: a = '1;
      default: a = {8'($urandom), 32'($urandom)};
    endcase
    return a;
  endfunction

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_short_address_crc();
    set_config(3'd3, 40'hFF_FFFF_FFFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7E, 1'b1);
    set_config(3'd4, 40'h12_3456_789A, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  // out-of-range lengths behave as the nearest legal one
  task automatic test_alen_clamp();
    set_config(3'd0, rand_addr(), 1'b1);
    send_byte(8'h3C, 1'b1);
    set_config(3'd7, rand_addr(), 1'b0);
    send_byte(8'h5A, 1'b1);
    set_config(3'd2, rand_addr(), 1'b0);
    send_byte(8'h0F, 1'b1);
    set_config(3'd6, rand_addr(), 1'b1);
    send_byte(8'hF0, 1'b1);
  endtask

  task automatic test_mid_packet_config();
    set_config(3'd4, 40'hA5_5AA5_5AA5, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    set_config(3'd3, 40'h00_00C0_FFEE, 1'b1);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  // overlong packets: drops with and without CRC, last item dropped
  task automatic test_length_limits();
    set_config(3'd3, rand_addr(), 1'b0);
    send_packet(30);
    set_config(3'd5, rand_addr(), 1'b1);
    send_packet(27);
    set_config(3'd3, rand_addr(), 1'b1);
    send_packet(28);
    set_config(3'd4, rand_addr(), 1'b0);
    send_packet(29);
  endtask

  task automatic test_random_packets();
    int len;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0)
        set_config(3'($urandom_range(0, 7)), rand_addr(), 1'($urandom_range(0, 1)));
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 12);
      send_packet(len);
    end
  endtask

  // receiver: random back-pressure, compare against oldest pending byte
  initial begin
    pkt_item_t want;
    int        stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_gap(1);
      if (stall > 0) begin
        if (rdy_up) begin
          pk_if.ready <= 1'b0;
          rdy_up = 1'b0;
        end
        repeat (stall) @(posedge clk);
      end
      pk_if.ready <= 1'b1;
      rdy_up = 1'b1;
      do @(posedge clk); while (!pk_if.valid);
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected item: byte %h kind %0d eop %b err %b", pk_if.packet_byte,
                   pk_if.byte_kind, pk_if.end_of_packet, pk_if.length_error);
      end else begin
        want = pending_bytes.pop_front();
        if (pk_if.packet_byte !== want.pkt_byte || pk_if.byte_kind !== want.kind ||
            pk_if.end_of_packet !== want.eop || pk_if.length_error !== want.err) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: byte %h/%h kind %0d/%0d eop %b/%b err %b/%b (exp/act)",
                     want.pkt_byte, pk_if.packet_byte, want.kind, pk_if.byte_kind,
                     want.eop, pk_if.end_of_packet, want.err, pk_if.length_error);
        end
      end
    end
  end

  initial begin
    pl_if.valid          <= 1'b0;
    pl_if.payload_byte   <= 8'h00;
    pl_if.end_of_payload <= 1'b0;
    pk_if.ready          <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= spce_pkg::CFG_ADDRESS_LENGTH;
    cfg_if.data          <= '0;
    reg_alen   = 3'd5;
    reg_addr   = '0;
    reg_crc_en = 1'b0;
    crc_acc    = SEED;
    pay_idx    = 0;
    in_pkt     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_short_address_crc();
    test_alen_clamp();
    test_mid_packet_config();
    items_sent = 0;
    test_length_limits();
    test_random_packets();
    wait_drained();
    if (cfg_up) begin
      cfg_if.valid <= 1'b0;
      cfg_up = 1'b0;
    end
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
design/spce_pkg.sv
design/spce_if.sv
design/spce_queue.sv
design/spce_front.sv
design/spce_back.sv
design/scrambled_packet_crc_encoder.sv
design/spce_checker.sv
dv/scrambled_packet_crc_encoder_test.sv
